// ===== rtl/core/ppbd_pkg.sv =====
// Shared types and constants of the planar PackBits decoder.
package ppbd_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned ADDR_W      = 34;
  localparam int unsigned COL_W       = 17;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT = 2'd3;

  // Headers above this value start a repeat run
  localparam logic [7:0] LITERAL_LIMIT = 8'h7F;
  // Repeat length is this base minus the header byte
  localparam logic [8:0] REPEAT_BASE   = 9'h101;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_LITERAL = 2'd1,
    PHASE_REPEAT  = 2'd2
  } phase_t;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

endpackage

// ===== rtl/core/ppbd_if.sv =====
// Channel interfaces of the planar PackBits decoder: configuration, input bytes, runs.
interface ppbd_cfg_if;
  logic                  valid;
  logic                  ready;
  ppbd_pkg::cfg_index_t  index;
  ppbd_pkg::cfg_data_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface ppbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppbd_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          value;
  ppbd_pkg::addr_t     start_address;
  logic [7:0]          run_length;
  logic [1:0]          plane_index;
  logic                image_done;
  modport source (output valid, output value, output start_address, output run_length,
                  output plane_index, output image_done, input ready);
  modport sink   (input valid, input value, input start_address, input run_length,
                  input plane_index, input image_done, output ready);
endinterface

// ===== rtl/core/planar_packbits_decoder.sv =====
// Planar PackBits decoder: turns a byte stream into interleaved pixel run descriptors.
// Takes one byte per clock unless a held result stalls it, and gives at most one run per byte.
// A byte lands in an input register and is decoded into the result register once that register
// is free or being drained; with out_ch.ready held high the block sustains one byte per cycle,
// updating the decode phase and position counters for every byte.
// Header bytes in compressed mode give no run. After the final run of the image (flagged
// by image_done) all further bytes are taken and dropped until reset. Write configuration
// only while no byte is in flight.
module planar_packbits_decoder (
  input  logic              clk,
  input  logic              rst_n,
  ppbd_cfg_if.sink          cfg_ch,
  ppbd_in_if.sink           in_ch,
  ppbd_out_if.source        out_ch
);

  // configuration
  logic        compressed_r;
  logic [15:0] row_bytes_r;
  logic [15:0] row_count_r;
  logic [1:0]  plane_count_r;

  // input register
  logic       byte_v_r;
  logic [7:0] byte_r;

  // decode state
  ppbd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]                   literal_left_r, literal_left_nxt;
  logic [7:0]                   repeat_length_r, repeat_length_nxt;
  logic [ppbd_pkg::COL_W-1:0]   column_pos_r, column_pos_nxt;
  logic [15:0]                  row_pos_r, row_pos_nxt;
  logic [1:0]                   plane_pos_r, plane_pos_nxt;
  ppbd_pkg::addr_t              next_address_r, next_address_nxt;
  logic                         finished_r, finished_nxt;

  // result register
  logic            out_v_r;
  logic [7:0]      out_value_r;
  ppbd_pkg::addr_t out_addr_r;
  logic [7:0]      out_len_r;
  logic [1:0]      out_plane_r;
  logic            out_done_r;

  logic                       advance;
  logic                       emit;
  logic                       run_complete;
  logic [7:0]                 run_len;
  logic [7:0]                 lit_dec;
  logic [1:0]                 stride;
  logic [9:0]                 addr_step;
  logic [ppbd_pkg::COL_W-1:0] col_sum;
  logic                       row_close;
  logic                       row_last;
  logic                       plane_last;
  logic                       run_done;
  logic [8:0]                 repeat_calc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r  <= 1'b1;
      row_bytes_r   <= 16'd1;
      row_count_r   <= 16'd1;
      plane_count_r <= 2'd3;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ppbd_pkg::CFG_COMPRESSED:  compressed_r  <= cfg_ch.data[0];
        ppbd_pkg::CFG_ROW_BYTES:   row_bytes_r   <= cfg_ch.data;
        ppbd_pkg::CFG_ROW_COUNT:   row_count_r   <= cfg_ch.data;
        ppbd_pkg::CFG_PLANE_COUNT: plane_count_r <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  // decode stage moves when the result register is free or being drained
  assign advance     = byte_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !byte_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      byte_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.data_byte;
    end
  end

  // phase decode
  always_comb begin
    phase_nxt         = phase_r;
    literal_left_nxt  = literal_left_r;
    repeat_length_nxt = repeat_length_r;
    emit              = 1'b0;
    run_complete      = 1'b1;
    run_len           = 8'd1;
    lit_dec           = literal_left_r - 8'd1;
    repeat_calc       = ppbd_pkg::REPEAT_BASE - {1'b0, byte_r};
    if (!finished_r) begin
      if (!compressed_r) begin
        phase_nxt         = ppbd_pkg::PHASE_HEADER;
        literal_left_nxt  = 8'd0;
        repeat_length_nxt = 8'd0;
        emit              = 1'b1;
      end else begin
        case (phase_r)
          ppbd_pkg::PHASE_LITERAL: begin
            literal_left_nxt = lit_dec;
            if (lit_dec == 8'd0) begin
              phase_nxt = ppbd_pkg::PHASE_HEADER;
            end
            emit         = 1'b1;
            run_complete = (lit_dec == 8'd0);
          end
          ppbd_pkg::PHASE_REPEAT: begin
            run_len           = repeat_length_r;
            phase_nxt         = ppbd_pkg::PHASE_HEADER;
            repeat_length_nxt = 8'd0;
            emit              = 1'b1;
          end
          default: begin
            if (byte_r > ppbd_pkg::LITERAL_LIMIT) begin
              repeat_length_nxt = repeat_calc[7:0];
              phase_nxt         = ppbd_pkg::PHASE_REPEAT;
            end else begin
              literal_left_nxt = byte_r + 8'd1;
              phase_nxt        = ppbd_pkg::PHASE_LITERAL;
            end
          end
        endcase
      end
    end
  end

  // position update for an emitted run
  assign stride     = (plane_count_r == 2'd0) ? 2'd1 : plane_count_r;
  assign addr_step  = {2'b00, run_len} * {8'd0, stride};
  assign col_sum    = column_pos_r + {{(ppbd_pkg::COL_W-8){1'b0}}, run_len};
  assign row_close  = run_complete && (col_sum >= {1'b0, row_bytes_r});
  assign row_last   = ({1'b0, row_pos_r} + 17'd1) >= {1'b0, row_count_r};
  assign plane_last = ({1'b0, plane_pos_r} + 3'd1) >= {1'b0, stride};

  always_comb begin
    column_pos_nxt   = column_pos_r;
    row_pos_nxt      = row_pos_r;
    plane_pos_nxt    = plane_pos_r;
    next_address_nxt = next_address_r;
    finished_nxt     = finished_r;
    run_done         = 1'b0;
    if (emit) begin
      next_address_nxt = next_address_r + {{(ppbd_pkg::ADDR_W-10){1'b0}}, addr_step};
      column_pos_nxt   = col_sum;
      if (row_close) begin
        column_pos_nxt = '0;
        if (row_last) begin
          row_pos_nxt = 16'd0;
          if (plane_last) begin
            finished_nxt = 1'b1;
            run_done     = 1'b1;
          end else begin
            plane_pos_nxt    = plane_pos_r + 2'd1;
            next_address_nxt = {{(ppbd_pkg::ADDR_W-2){1'b0}}, plane_pos_nxt};
          end
        end else begin
          row_pos_nxt = row_pos_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ppbd_pkg::PHASE_HEADER;
      literal_left_r  <= 8'd0;
      repeat_length_r <= 8'd0;
      column_pos_r    <= '0;
      row_pos_r       <= 16'd0;
      plane_pos_r     <= 2'd0;
      next_address_r  <= '0;
      finished_r      <= 1'b0;
    end else if (advance) begin
      phase_r         <= phase_nxt;
      literal_left_r  <= literal_left_nxt;
      repeat_length_r <= repeat_length_nxt;
      column_pos_r    <= column_pos_nxt;
      row_pos_r       <= row_pos_nxt;
      plane_pos_r     <= plane_pos_nxt;
      next_address_r  <= next_address_nxt;
      finished_r      <= finished_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= emit;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_value_r <= byte_r;
      out_addr_r  <= next_address_r;
      out_len_r   <= run_len;
      out_plane_r <= plane_pos_r;
      out_done_r  <= run_done;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.value         = out_value_r;
  assign out_ch.start_address = out_addr_r;
  assign out_ch.run_length    = out_len_r;
  assign out_ch.plane_index   = out_plane_r;
  assign out_ch.image_done    = out_done_r;

endmodule
